>>> hw/rtl/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// Shared types, codes and the keyword trie of the four-letter tokenizer.
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int unsigned InDataW    = 8;
  localparam int unsigned InUserW    = 1;
  localparam int unsigned OutDataW   = 136;
  localparam int unsigned OutUserW   = 8;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChI       = 8'h69;
  localparam logic [7:0] ChBigI    = 8'h49;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChEll     = 8'h6C;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    LcI    = 2'd0,
    LcBigI = 2'd1,
    LcOne  = 2'd2,
    LcEll  = 2'd3
  } letter_e;

  typedef enum logic [4:0] {
    TkNum      = 5'd0,
    TkVid      = 5'd1,
    TkFid      = 5'd2,
    TkProgram  = 5'd3,
    TkLbrace   = 5'd4,
    TkRbrace   = 5'd5,
    TkVar      = 5'd6,
    TkAssign   = 5'd7,
    TkLparen   = 5'd8,
    TkRparen   = 5'd9,
    TkFunction = 5'd10,
    TkSemi     = 5'd11,
    TkPlus     = 5'd12,
    TkMinus    = 5'd13,
    TkTimes    = 5'd14,
    TkDiv      = 5'd15,
    TkExp      = 5'd16,
    TkGt       = 5'd17,
    TkLt       = 5'd18,
    TkEq       = 5'd19,
    TkNeq      = 5'd20,
    TkIf       = 5'd21,
    TkElse     = 5'd22,
    TkEnd      = 5'd23,
    TkError    = 5'd24
  } token_kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrBadStart = 3'd1,
    ErrBadName  = 3'd2,
    ErrNotOne   = 3'd3,
    ErrKeyword  = 3'd4,
    ErrEndLen   = 3'd5
  } error_kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgFirstLine   = 1'b0,
    CfgFirstColumn = 1'b1
  } cfg_index_e;

  // one classified source byte
  typedef struct packed {
    letter_e letter;
    logic    is_letter;
    logic    is_space;
    logic    is_newline;
    logic    end_mark;
  } flt_item_t;

  typedef struct packed {
    logic                 valid;
    cfg_index_e           index;
    logic [CfgDataW-1:0]  data;
  } flt_cfg_wr_t;

  typedef struct packed {
    logic        hit;
    token_kind_e kind;
  } kw_entry_t;

  // three letters after the leading l, first letter in the top bits
  function automatic kw_entry_t kw_lookup(input logic [5:0] idx);
    kw_entry_t e;
    e.hit  = 1'b1;
    e.kind = TkNum;
    unique case (idx)
      6'd0:    e.kind = TkExp;
      6'd3:    e.kind = TkTimes;
      6'd6:    e.kind = TkVar;
      6'd9:    e.kind = TkProgram;
      6'd11:   e.kind = TkLparen;
      6'd14:   e.kind = TkRparen;
      6'd18:   e.kind = TkAssign;
      6'd24:   e.kind = TkFunction;
      6'd32:   e.kind = TkSemi;
      6'd33:   e.kind = TkLbrace;
      6'd34:   e.kind = TkIf;
      6'd35:   e.kind = TkElse;
      6'd36:   e.kind = TkRbrace;
      6'd42:   e.kind = TkNeq;
      6'd48:   e.kind = TkMinus;
      6'd51:   e.kind = TkDiv;
      6'd56:   e.kind = TkGt;
      6'd57:   e.kind = TkLt;
      6'd58:   e.kind = TkEq;
      6'd60:   e.kind = TkPlus;
      default: e.hit  = 1'b0;
    endcase
    return e;
  endfunction

  // two-letter prefixes that still lead to some keyword
  function automatic logic kw_prefix_ok(input logic [3:0] p);
    logic ok;
    ok = 1'b1;
    unique case (p) inside
      4'd5, 4'd7, 4'd11, 4'd13: ok = 1'b0;
      default:                  ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

>>> hw/rtl/flt_front.sv
// ----------------------------------------------------------------------------
// flt_front
// Input side: takes source bytes and classifies them for the scanner.
// ----------------------------------------------------------------------------
module flt_front
  import flt_pkg::*;
(
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,  // char_code
  input  logic [InUserW-1:0] s_axis_tuser_i,  // end_of_input
  input  logic               queue_ready_i,
  output logic               push_valid_o,
  output flt_item_t          item_o
);

  logic [7:0] ch;

  assign ch              = s_axis_tdata_i;
  assign s_axis_tready_o = queue_ready_i;
  assign push_valid_o    = s_axis_tvalid_i;

  always_comb begin
    item_o.letter     = LcI;
    item_o.is_letter  = 1'b1;
    item_o.is_space   = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
    item_o.is_newline = (ch == ChNewline);
    item_o.end_mark   = s_axis_tuser_i[0];
    unique case (ch)
      ChI:     item_o.letter = LcI;
      ChBigI:  item_o.letter = LcBigI;
      ChOne:   item_o.letter = LcOne;
      ChEll:   item_o.letter = LcEll;
      default: item_o.is_letter = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/flt_queue.sv
// ----------------------------------------------------------------------------
// flt_queue
// Short queue of classified bytes between the front and the scanner.
// ----------------------------------------------------------------------------
module flt_queue
  import flt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  flt_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output flt_item_t pop_item_o
);

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  flt_item_t         store_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CountW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hw/rtl/flt_back.sv
// ----------------------------------------------------------------------------
// flt_back
// Scanner: token state machine, position tracking and the output register.
// ----------------------------------------------------------------------------
module flt_back
  import flt_pkg::*;
#(
  parameter int unsigned MaxNameChars = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  flt_cfg_wr_t         cfg_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  flt_item_t           item_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  localparam int unsigned NameW = 2 * MaxNameChars;
  localparam int unsigned CntW  = $clog2(MaxNameChars + 1);
  localparam int unsigned IdxW  = (MaxNameChars > 1) ? $clog2(MaxNameChars) : 1;

  typedef enum logic [5:0] {
    ModeIdle = 6'b000001,
    ModeVid  = 6'b000010,
    ModeFid  = 6'b000100,
    ModeNum  = 6'b001000,
    ModeKw   = 6'b010000,
    ModeHalt = 6'b100000
  } scan_mode_e;

  scan_mode_e       mode_q, mode_d;
  logic [3:0]       kw_prefix_q, kw_prefix_d;
  logic [1:0]       kw_seen_q, kw_seen_d;
  logic [30:0]      ones_q, ones_d;
  logic [NameW-1:0] name_q, name_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      first_col_q;
  logic [15:0]      cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [15:0]      start_line_q, start_line_d, start_col_q, start_col_d;
  logic [15:0]      adv_line, adv_col;
  logic             out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  logic             fire, emit;
  token_kind_e      emit_kind;
  error_kind_e      emit_err;
  logic [30:0]      emit_num;
  logic [NameW-1:0] emit_name;
  logic [CntW-1:0]  emit_len;
  logic [3:0]       kw_pair;
  kw_entry_t        kw_hit;

  assign item_ready_o    = !out_valid_q || m_axis_tready_i;
  assign fire            = item_valid_i && item_ready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  assign kw_pair = {kw_prefix_q[1:0], item_i.letter};
  assign kw_hit  = kw_lookup({kw_prefix_q, item_i.letter});

  // saturating position step for the byte being consumed
  always_comb begin
    if (item_i.is_newline) begin
      adv_line = (cur_line_q == 16'hFFFF) ? cur_line_q : cur_line_q + 16'd1;
      adv_col  = first_col_q;
    end else begin
      adv_line = cur_line_q;
      adv_col  = (cur_col_q == 16'hFFFF) ? cur_col_q : cur_col_q + 16'd1;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    kw_prefix_d  = kw_prefix_q;
    kw_seen_d    = kw_seen_q;
    ones_d       = ones_q;
    name_d       = name_q;
    cnt_d        = cnt_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    emit         = 1'b0;
    emit_kind    = TkNum;
    emit_err     = ErrNone;
    emit_num     = '0;
    emit_name    = '0;
    emit_len     = '0;

    if (fire && (mode_q != ModeHalt)) begin
      if (item_i.end_mark) begin
        emit = 1'b1;
        if (mode_q == ModeIdle) begin
          start_line_d = cur_line_q;
          start_col_d  = cur_col_q;
          emit_kind    = TkEnd;
        end else begin
          mode_d    = ModeHalt;
          emit_kind = TkError;
          emit_err  = ErrEndLen;
        end
      end else begin
        unique case (mode_q)
          ModeIdle: begin
            if (item_i.is_space) begin
              cur_line_d = adv_line;
              cur_col_d  = adv_col;
            end else begin
              start_line_d = cur_line_q;
              start_col_d  = cur_col_q;
              if (!item_i.is_letter) begin
                mode_d    = ModeHalt;
                emit      = 1'b1;
                emit_kind = TkError;
                emit_err  = ErrBadStart;
              end else begin
                cur_line_d = adv_line;
                cur_col_d  = adv_col;
                unique case (item_i.letter)
                  LcI, LcBigI: begin
                    mode_d = (item_i.letter == LcI) ? ModeVid : ModeFid;
                    name_d = NameW'(item_i.letter);
                    cnt_d  = CntW'(1);
                  end
                  LcOne: begin
                    mode_d = ModeNum;
                    ones_d = '0;
                  end
                  default: begin
                    mode_d      = ModeKw;
                    kw_prefix_d = '0;
                    kw_seen_d   = '0;
                  end
                endcase
              end
            end
          end
          ModeVid, ModeFid: begin
            cur_line_d = adv_line;
            cur_col_d  = adv_col;
            if (item_i.is_space) begin
              mode_d    = ModeIdle;
              emit      = 1'b1;
              emit_kind = (mode_q == ModeVid) ? TkVid : TkFid;
              emit_name = name_q;
              emit_len  = cnt_q;
            end else if (!item_i.is_letter) begin
              mode_d    = ModeHalt;
              emit      = 1'b1;
              emit_kind = TkError;
              emit_err  = ErrBadName;
            end else if (cnt_q >= CntW'(MaxNameChars)) begin
              mode_d    = ModeHalt;
              emit      = 1'b1;
              emit_kind = TkError;
              emit_err  = ErrEndLen;
            end else begin
              name_d[{cnt_q[IdxW-1:0], 1'b0} +: 2] = item_i.letter;
              cnt_d = cnt_q + CntW'(1);
            end
          end
          ModeNum: begin
            cur_line_d = adv_line;
            cur_col_d  = adv_col;
            if (item_i.is_space) begin
              mode_d    = ModeIdle;
              emit      = 1'b1;
              emit_kind = TkNum;
              emit_num  = ones_q;
            end else if (!item_i.is_letter || (item_i.letter != LcOne)) begin
              mode_d    = ModeHalt;
              emit      = 1'b1;
              emit_kind = TkError;
              emit_err  = ErrNotOne;
            end else if (ones_q != '1) begin
              ones_d = ones_q + 31'd1;
            end
          end
          ModeKw: begin
            cur_line_d = adv_line;
            cur_col_d  = adv_col;
            if (!item_i.is_letter) begin
              mode_d    = ModeHalt;
              emit      = 1'b1;
              emit_kind = TkError;
              emit_err  = ErrKeyword;
            end else if (kw_seen_q == 2'd0) begin
              kw_prefix_d = {2'b00, item_i.letter};
              kw_seen_d   = 2'd1;
            end else if (kw_seen_q == 2'd1) begin
              if (kw_prefix_ok(kw_pair)) begin
                kw_prefix_d = kw_pair;
                kw_seen_d   = 2'd2;
              end else begin
                mode_d    = ModeHalt;
                emit      = 1'b1;
                emit_kind = TkError;
                emit_err  = ErrKeyword;
              end
            end else if (kw_hit.hit) begin
              mode_d      = ModeIdle;
              kw_seen_d   = '0;
              kw_prefix_d = '0;
              emit        = 1'b1;
              emit_kind   = kw_hit.kind;
            end else begin
              mode_d    = ModeHalt;
              emit      = 1'b1;
              emit_kind = TkError;
              emit_err  = ErrKeyword;
            end
          end
          default: ;
        endcase
      end
    end

    // register writes reload the running position
    if (cfg_i.valid) begin
      if (cfg_i.index == CfgFirstLine) begin
        cur_line_d = cfg_i.data;
      end else begin
        cur_col_d = cfg_i.data;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      kw_prefix_q  <= '0;
      kw_seen_q    <= '0;
      ones_q       <= '0;
      name_q       <= '0;
      cnt_q        <= '0;
      first_col_q  <= 16'd0;
      cur_line_q   <= 16'd1;
      cur_col_q    <= 16'd0;
      start_line_q <= '0;
      start_col_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      kw_prefix_q  <= kw_prefix_d;
      kw_seen_q    <= kw_seen_d;
      ones_q       <= ones_d;
      name_q       <= name_d;
      cnt_q        <= cnt_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid && (cfg_i.index == CfgFirstColumn)) begin
        first_col_q <= cfg_i.data;
      end
    end
  end

  // result beat: tuser {error_kind, token_kind}, tdata packed low to high
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_user_q <= {emit_err, emit_kind};
      out_data_q <= {3'b000, start_col_d, start_line_d, 6'(emit_len),
                     64'(emit_name), emit_num};
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeHalt) |=> (mode_q == ModeHalt))
    else $error("scanner left the halted state");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (emit_kind == TkError)) |=> (mode_q == ModeHalt))
    else $error("error token without halt");

  a_silent_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeHalt) |-> !emit)
    else $error("token produced while halted");

  a_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxNameChars))
    else $error("name letter count beyond limit");
`endif

endmodule

>>> hw/rtl/four_letter_language_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// four_letter_language_tokenizer_unit
// Byte-stream tokenizer for the four-letter language, with line/column tags.
// ----------------------------------------------------------------------------
// Takes one source byte per beat and sustains one byte per clock cycle while
// the queue has room; each byte is a single update of the scanner state
// machine. A token reaches the result stream through the two-entry input
// queue and then the output register, and the input keeps flowing while a
// finished token waits to be taken until the queue fills. After an error
// token the block drops all further bytes until reset. Register writes are
// meant for idle periods only.
module four_letter_language_tokenizer_unit
  import flt_pkg::*;
#(
  parameter int unsigned MaxNameChars = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // char_code
  input  logic [InUserW-1:0]   s_axis_tuser_i,   // end_of_input
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // number_value, name_letters, name_length, token_line, token_column, zero pad
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  output logic [OutUserW-1:0]  m_axis_tuser_o,   // token_kind, error_kind
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  flt_item_t   front_item, queue_item;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  flt_cfg_wr_t cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  flt_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_ready_i   (push_ready),
    .push_valid_o    (push_valid),
    .item_o          (front_item)
  );

  flt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (queue_item)
  );

  flt_back #(
    .MaxNameChars (MaxNameChars)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_wr),
    .item_valid_i    (pop_valid),
    .item_ready_o    (pop_ready),
    .item_i          (queue_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> tb/four_letter_language_tokenizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_letter_language_tokenizer_unit_test
// Self-checking bench for the four-letter tokenizer. A scanner model inside a
// scoreboard class predicts every token and its position from the accepted
// bytes. Streams of well-formed tokens run under several line/column origins,
// with random stalls on both sides. A single error scenario closes the run.
// ----------------------------------------------------------------------------
package flt_tb_pkg;
  import flt_pkg::*;

  typedef enum logic [2:0] {
    ScanIdle,
    ScanVid,
    ScanFid,
    ScanNum,
    ScanKw,
    ScanHalt
  } scan_e;

  localparam int          NotLetter    = 4;
  localparam int          NameLimit    = 32;
  localparam logic [30:0] OnesMax      = '1;
  localparam logic [7:0]  ChVtab       = 8'h0B;
  localparam logic [7:0]  ChFeed       = 8'h0C;

  typedef struct {
    token_kind_e kind;
    error_kind_e err;
    logic [30:0] count;
    logic [63:0] letters;
    logic [5:0]  len;
    logic [15:0] line;
    logic [15:0] column;
  } token_t;

  function automatic int letter_code(input logic [7:0] c);
    case (c)
      ChI:     return 0;
      ChBigI:  return 1;
      ChOne:   return 2;
      ChEll:   return 3;
      default: return NotLetter;
    endcase
  endfunction

  function automatic logic [7:0] letter_char(input int code);
    case (code)
      0:       return ChI;
      1:       return ChBigI;
      2:       return ChOne;
      default: return ChEll;
    endcase
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  // three letters after the leading l, first letter in the top bits
  function automatic bit keyword_at(input logic [5:0] idx, output token_kind_e k);
    k = TkNum;
    keyword_at = 1'b1;
    case (idx)
      6'd0:    k = TkExp;
      6'd3:    k = TkTimes;
      6'd6:    k = TkVar;
      6'd9:    k = TkProgram;
      6'd11:   k = TkLparen;
      6'd14:   k = TkRparen;
      6'd18:   k = TkAssign;
      6'd24:   k = TkFunction;
      6'd32:   k = TkSemi;
      6'd33:   k = TkLbrace;
      6'd34:   k = TkIf;
      6'd35:   k = TkElse;
      6'd36:   k = TkRbrace;
      6'd42:   k = TkNeq;
      6'd48:   k = TkMinus;
      6'd51:   k = TkDiv;
      6'd56:   k = TkGt;
      6'd57:   k = TkLt;
      6'd58:   k = TkEq;
      6'd60:   k = TkPlus;
      default: keyword_at = 1'b0;
    endcase
  endfunction

  function automatic string show(input token_t t);
    return $sformatf("kind %0d err %0d num %0d letters %h len %0d at %0d:%0d",
                     t.kind, t.err, t.count, t.letters, t.len, t.line, t.column);
  endfunction

  class token_scoreboard;
    logic [15:0] line_base, col_base, cur_line, cur_col, tok_line, tok_col;
    scan_e       mode;
    logic [3:0]  kw_prefix;
    int          kw_seen;
    logic [30:0] ones;
    logic [63:0] name_bits;
    logic [5:0]  name_len;
    token_t      token_q[$];
    int          mismatches;

    function new();
      line_base  = 16'd1;
      col_base   = 16'd0;
      cur_line   = 16'd1;
      cur_col    = 16'd0;
      tok_line   = 16'd0;
      tok_col    = 16'd0;
      mode       = ScanIdle;
      kw_prefix  = '0;
      kw_seen    = 0;
      ones       = '0;
      name_bits  = '0;
      name_len   = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function void write_reg(input cfg_index_e idx, input logic [15:0] v);
      if (idx == CfgFirstLine) begin
        line_base = v;
        cur_line  = v;
      end else begin
        col_base = v;
        cur_col  = v;
      end
    endfunction

    function void step_position(input logic [7:0] c);
      if (c == ChNewline) begin
        if (cur_line != 16'hFFFF) cur_line++;
        cur_col = col_base;
      end else if (cur_col != 16'hFFFF) begin
        cur_col++;
      end
    endfunction

    function void push(input token_kind_e k, input error_kind_e e, input logic [30:0] n,
                       input logic [63:0] l, input logic [5:0] len);
      token_t t;
      t.kind    = k;
      t.err     = e;
      t.count   = n;
      t.letters = l;
      t.len     = len;
      t.line    = tok_line;
      t.column  = tok_col;
      token_q.push_back(t);
    endfunction

    function void halt(input error_kind_e e);
      mode = ScanHalt;
      push(TkError, e, '0, '0, '0);
    endfunction

    function void note_input(input logic [7:0] c, input logic eoi);
      int          lc;
      bit          ok;
      logic [3:0]  p;
      token_kind_e k;
      lc = letter_code(c);
      if (mode == ScanHalt) return;
      if (eoi) begin
        if (mode == ScanIdle) begin
          tok_line = cur_line;
          tok_col  = cur_col;
          push(TkEnd, ErrNone, '0, '0, '0);
        end else begin
          halt(ErrEndLen);
        end
        return;
      end
      case (mode)
        ScanIdle: begin
          if (is_blank(c)) begin
            step_position(c);
            return;
          end
          tok_line = cur_line;
          tok_col  = cur_col;
          if (lc == NotLetter) begin
            halt(ErrBadStart);
            return;
          end
          step_position(c);
          case (lc)
            0, 1: begin
              mode      = (lc == 0) ? ScanVid : ScanFid;
              name_bits = 64'(lc);
              name_len  = 6'd1;
            end
            2: begin
              mode = ScanNum;
              ones = '0;
            end
            default: begin
              mode      = ScanKw;
              kw_prefix = '0;
              kw_seen   = 0;
            end
          endcase
        end
        ScanVid, ScanFid: begin
          step_position(c);
          if (is_blank(c)) begin
            push((mode == ScanVid) ? TkVid : TkFid, ErrNone, '0, name_bits, name_len);
            mode = ScanIdle;
          end else if (lc == NotLetter) begin
            halt(ErrBadName);
          end else if (name_len >= NameLimit) begin
            halt(ErrEndLen);
          end else begin
            name_bits |= 64'(lc) << (2 * name_len);
            name_len++;
          end
        end
        ScanNum: begin
          step_position(c);
          if (is_blank(c)) begin
            push(TkNum, ErrNone, ones, '0, '0);
            mode = ScanIdle;
          end else if (lc != 2) begin
            halt(ErrNotOne);
          end else if (ones != OnesMax) begin
            ones++;
          end
        end
        ScanKw: begin
          step_position(c);
          if (lc == NotLetter) begin
            halt(ErrKeyword);
          end else if (kw_seen == 0) begin
            kw_prefix = 4'(lc);
            kw_seen   = 1;
          end else if (kw_seen == 1) begin
            // the prefix must still lead to at least one keyword
            p  = {kw_prefix[1:0], 2'(lc)};
            ok = 1'b0;
            for (int j = 0; j < 4; j++) if (keyword_at({p, 2'(j)}, k)) ok = 1'b1;
            if (!ok) begin
              halt(ErrKeyword);
            end else begin
              kw_prefix = p;
              kw_seen   = 2;
            end
          end else if (keyword_at({kw_prefix, 2'(lc)}, k)) begin
            push(k, ErrNone, '0, '0, '0);
            mode      = ScanIdle;
            kw_seen   = 0;
            kw_prefix = '0;
          end else begin
            halt(ErrKeyword);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(input logic [OutDataW-1:0] data, input logic [OutUserW-1:0] user);
      token_t got, want;
      got.kind    = token_kind_e'(user[4:0]);
      got.err     = error_kind_e'(user[7:5]);
      got.count   = data[30:0];
      got.letters = data[94:31];
      got.len     = data[100:95];
      got.line    = data[116:101];
      got.column  = data[132:117];
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token: %s", show(got));
        return;
      end
      want = token_q.pop_front();
      if (got.kind !== want.kind || got.err !== want.err || got.count !== want.count ||
          got.letters !== want.letters || got.len !== want.len ||
          got.line !== want.line || got.column !== want.column) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch at %0t", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

module four_letter_language_tokenizer_unit_test;
  import flt_pkg::*;
  import flt_tb_pkg::*;

  localparam int HoldCycles   = 150;
  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes   = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [InDataW-1:0]   s_tdata = '0;
  logic [InUserW-1:0]   s_tuser = '0;
  logic                 m_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutDataW-1:0]  m_axis_tdata_o;
  logic [OutUserW-1:0]  m_axis_tuser_o;
  logic                 cfg_ready_o;

  token_scoreboard sb;
  logic quiet = 1'b0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   rx_stall = 0;
  int   stall_cycles = 0;
  int   phase_bytes = 0;

  four_letter_language_tokenizer_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_stray();
    logic [7:0] c;
    do c = 8'($urandom); while (is_blank(c) || letter_code(c) != NotLetter);
    return c;
  endfunction

  // result side: check each beat, then decide on the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_tready) sb.check(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_stall  = HoldCycles;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        rx_stall = pick_gap();
        m_tready <= (rx_stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
          (cfg_valid && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("four_letter_language_tokenizer_unit test failed");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= eoi;
    do @(posedge clk); while (!s_axis_tready_o);
    sb.note_input(c, eoi);
    phase_bytes++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_letter(input int code);
    send_byte(letter_char(code), 1'b0);
  endtask

  task automatic send_blank();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 5))
        0:       c = ChSpace;
        1:       c = ChNewline;
        2:       c = ChTab;
        3:       c = ChVtab;
        4:       c = ChFeed;
        default: c = ChCr;
      endcase
      send_byte(c, 1'b0);
    end
  endtask

  task automatic send_keyword(input logic [5:0] idx);
    send_byte(ChEll, 1'b0);
    send_letter(int'(idx[5:4]));
    send_letter(int'(idx[3:2]));
    send_letter(int'(idx[1:0]));
  endtask

  task automatic send_token();
    int          r, n;
    logic [5:0]  idx;
    token_kind_e k;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      n = ($urandom_range(0, 29) == 0) ? NameLimit : $urandom_range(1, 6);
      send_letter($urandom_range(0, 1));
      repeat (n - 1) send_letter($urandom_range(0, 3));
      send_blank();
    end else if (r < 50) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      repeat (n + 1) send_byte(ChOne, 1'b0);
      send_blank();
    end else if (r < 92) begin
      do idx = 6'($urandom); while (!keyword_at(idx, k));
      send_keyword(idx);
      if ($urandom_range(0, 1)) send_blank();
    end else begin
      send_byte(8'($urandom), 1'b1);
      if ($urandom_range(0, 1)) send_blank();
    end
  endtask

  // stop sending and let every token and any queued byte work through
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_origin(input logic [15:0] first_line, input logic [15:0] first_col);
    cfg_index_e idx;
    bit         col_first;
    col_first = $urandom_range(0, 1);
    for (int i = 0; i < 2; i++) begin
      idx = ((i == 1) ^ col_first) ? CfgFirstColumn : CfgFirstLine;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= (idx == CfgFirstLine) ? first_line : first_col;
      do @(posedge clk); while (!cfg_ready_o);
      sb.write_reg(idx, (idx == CfgFirstLine) ? first_line : first_col);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] ln, cl;
    logic [7:0]  c;
    logic [5:0]  idx;
    token_kind_e k;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset origin, end mark, both name kinds, numbers, keywords, all blanks
    send_byte(ChSpace, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_text("i ");
    send_text("Il1I\n");
    send_text("1\t");
    send_text("111\r");
    send_text("llli");
    send_text("l1Ii");
    send_byte(ChVtab, 1'b0);
    send_byte(ChFeed, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin ln = 16'h0000; cl = 16'h0000; end
        1: begin ln = 16'hFFFF; cl = 16'hFFFF; end
        2: begin ln = 16'hFFFD; cl = 16'hFFF0; end
        5: begin ln = 16'h0001; cl = 16'h0000; end
        default: begin ln = 16'($urandom); cl = 16'($urandom); end
      endcase
      settle();
      set_origin(ln, cl);
      quiet <= (ph == 2);
      // long result stall while bytes keep coming, so the input backs up
      if (ph == 2) hold_req <= hold_req + 1;
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) send_token();
    end
    quiet <= 1'b0;

    // one fault to close the run, then bytes that must be dropped
    case ($urandom_range(0, 7))
      0: send_byte(pick_stray(), 1'b0);
      1: begin
        send_text("iI");
        send_byte(pick_stray(), 1'b0);
      end
      2: begin
        send_text("11");
        do c = 8'($urandom); while (c == ChOne || is_blank(c));
        send_byte(c, 1'b0);
      end
      3: send_text("lII");
      4: begin
        do idx = 6'($urandom); while (keyword_at(idx, k));
        send_keyword(idx);
      end
      5: begin
        send_text("l1");
        send_blank();
      end
      6: begin
        send_letter($urandom_range(0, 3));
        send_byte(8'($urandom), 1'b1);
      end
      default: begin
        send_byte(ChI, 1'b0);
        repeat (NameLimit) send_letter($urandom_range(0, 3));
      end
    endcase
    repeat (24) send_byte(8'($urandom), $urandom_range(0, 3) == 0);

    settle();
    if (sb.mismatches == 0) begin
      $display("four_letter_language_tokenizer_unit test passed");
    end else begin
      $display("four_letter_language_tokenizer_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/flt_pkg.sv
hw/rtl/flt_front.sv
hw/rtl/flt_queue.sv
hw/rtl/flt_back.sv
hw/rtl/four_letter_language_tokenizer_unit.sv
tb/four_letter_language_tokenizer_unit_test.sv
